FILE: src/chsc_pkg.sv
// constants and arctangent table for the clock hand sine and cosine block
package chsc_pkg;

    // cordic start vector, gain compensation 0.60725293 with 30 fraction bits
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;

    // 0.01 rad as a 32-bit fraction of one turn, used for step zero
    localparam logic [31:0] STEP_ZERO_TURN32 = 32'd6835653;

    // atan(2^-k) as a 32-bit fraction of one turn, rounded to nearest
    function automatic logic [31:0] atan_turn32(input int k);
        logic [31:0] v;
        case (k)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/clock_hand_sine_cosine.sv
// clock hand sine and cosine: pipelined modulo, phase divider and cordic
//
// usage: drive i_step and raise start for one cycle per item. busy is always
// low, so an item is taken in every cycle that start is high. each item gives
// one result on o_sine_x / o_cosine_y, marked by o_valid for exactly one cycle.
// the pipeline holds, in order:
// 16 restoring steps for step mod steps_per_turn, ANGLE_BITS restoring steps
// for the phase quotient, one rounding stage, one quadrant stage, one stage
// per cordic rotation, one quadrant swap and one output rounding stage.
// throughput is one item per cycle; each restoring step is one compare and
// subtract and each cordic rotation one add/sub triple. results cannot be held off by the receiver.
// steps_per_turn is written through i_cfg_we / i_cfg_data and resets to 60;
// a value of zero acts as one. write it only while no item is in flight.
// reset (synchronous, active low) clears all valid bits and sets the register to 60;
// items in flight at reset are dropped.
module clock_hand_sine_cosine
    import chsc_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int OUT_BITS      = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [15:0]                i_step,
    input  logic                       i_cfg_we,
    input  logic [15:0]                i_cfg_data,
    output logic                       o_valid,
    output logic signed [OUT_BITS-1:0] o_sine_x,
    output logic signed [OUT_BITS-1:0] o_cosine_y
);

    localparam int AB       = ANGLE_BITS;
    localparam int CS       = CORDIC_STAGES;
    localparam int XW       = 34;
    localparam int ZW       = 33;
    localparam int TURN_SH  = 32 - AB;
    localparam int ZP_RND   = (AB >= 32) ? 0 : 31 - AB;
    localparam logic [63:0] ZP64 = (AB >= 32) ? 64'(STEP_ZERO_TURN32) :
        ((64'(STEP_ZERO_TURN32) + (64'd1 << ZP_RND)) >> TURN_SH);
    localparam logic [AB-1:0] ZERO_PHASE = ZP64[AB-1:0];
    localparam int V_PH     = 16;
    localparam int V_RND    = 16 + AB;
    localparam int V_COR    = 17 + AB;
    localparam int V_SWP    = 18 + AB + CS;
    localparam int V_LEN    = 20 + AB + CS;
    localparam int OSH      = 31 - OUT_BITS;
    localparam int OSH_RND  = (OSH > 0) ? OSH - 1 : 0;
    localparam logic signed [35:0] OUT_HI = (36'sd1 <<< (OUT_BITS - 1)) - 36'sd1;
    localparam logic signed [35:0] OUT_LO = -OUT_HI - 36'sd1;

    // configuration register
    logic [15:0] r_steps;
    logic [15:0] w_n;
    logic [16:0] w_n17;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= 16'd60;
        end else if (i_cfg_we) begin
            r_steps <= i_cfg_data;
        end
    end

    assign w_n   = (r_steps == 16'd0) ? 16'd1 : r_steps;
    assign w_n17 = {1'b0, w_n};

    // valid bits
    logic [V_LEN-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[V_LEN-2:0], start && !busy};
        end
    end

    // modulo stages: restoring remainder, one step bit per stage
    logic [15:0] r_mrem  [16];
    logic [15:0] r_mstep [16];
    logic        r_mzero [16];
    logic [15:0] n_mrem  [16];
    logic [15:0] n_mstep [16];
    logic        n_mzero [16];
    logic [15:0] w_mrem_in  [16];
    logic [15:0] w_mstep_in [16];
    logic        w_mzero_in [16];

    always_comb begin
        logic [16:0] t;
        w_mrem_in[0]  = 16'd0;
        w_mstep_in[0] = i_step;
        w_mzero_in[0] = (i_step == 16'd0);
        for (int m = 1; m < 16; m++) begin
            w_mrem_in[m]  = r_mrem[m-1];
            w_mstep_in[m] = r_mstep[m-1];
            w_mzero_in[m] = r_mzero[m-1];
        end
        for (int m = 0; m < 16; m++) begin
            t = {w_mrem_in[m], w_mstep_in[m][15]};
            n_mrem[m]  = (t >= w_n17) ? 16'(t - w_n17) : t[15:0];
            n_mstep[m] = {w_mstep_in[m][14:0], 1'b0};
            n_mzero[m] = w_mzero_in[m];
        end
    end

    // phase divider stages: one quotient bit of r * 2^AB / n per stage
    logic [15:0]   r_prem  [AB];
    logic [AB-1:0] r_pq    [AB];
    logic          r_pzero [AB];
    logic [15:0]   n_prem  [AB];
    logic [AB-1:0] n_pq    [AB];
    logic          n_pzero [AB];
    logic [15:0]   w_prem_in  [AB];
    logic [AB-1:0] w_pq_in    [AB];
    logic          w_pzero_in [AB];

    always_comb begin
        logic [16:0] t;
        logic        ge;
        w_prem_in[0]  = r_mrem[15];
        w_pq_in[0]    = '0;
        w_pzero_in[0] = r_mzero[15];
        for (int p = 1; p < AB; p++) begin
            w_prem_in[p]  = r_prem[p-1];
            w_pq_in[p]    = r_pq[p-1];
            w_pzero_in[p] = r_pzero[p-1];
        end
        for (int p = 0; p < AB; p++) begin
            t  = {w_prem_in[p], 1'b0};
            ge = (t >= w_n17);
            n_prem[p]  = ge ? 16'(t - w_n17) : t[15:0];
            n_pq[p]    = {w_pq_in[p][AB-2:0], ge};
            n_pzero[p] = w_pzero_in[p];
        end
    end

    // rounding stage: add half of n, wrap a full circle to zero; step zero gives ZERO_PHASE
    logic [AB-1:0] r_phase;
    logic [AB-1:0] n_phase;
    logic [16:0]   w_rsum;

    always_comb begin
        w_rsum  = {1'b0, r_prem[AB-1]} + {2'b00, w_n[15:1]};
        n_phase = r_pq[AB-1] + AB'(w_rsum >= w_n17);
        if (r_pzero[AB-1]) begin
            n_phase = ZERO_PHASE;
        end
    end

    // quadrant stage and cordic rotations; index 0 is the quadrant stage
    logic signed [XW-1:0] r_cx [CS+1];
    logic signed [XW-1:0] r_cy [CS+1];
    logic signed [ZW-1:0] r_cz [CS+1];
    logic [1:0]           r_cq [CS+1];
    logic signed [XW-1:0] n_cx [CS+1];
    logic signed [XW-1:0] n_cy [CS+1];
    logic signed [ZW-1:0] n_cz [CS+1];
    logic [1:0]           n_cq [CS+1];
    logic [31:0]          w_t32;
    logic [31:0]          w_d;

    always_comb begin
        logic signed [ZW-1:0] a;
        w_t32   = 32'(r_phase) << TURN_SH;
        n_cq[0] = 2'((w_t32 + 32'h2000_0000) >> 30);
        w_d     = w_t32 - {n_cq[0], 30'd0};
        n_cz[0] = {w_d[31], w_d};
        n_cx[0] = XW'(signed'({1'b0, GAIN_Q30}));
        n_cy[0] = '0;
        for (int c = 1; c <= CS; c++) begin
            a = signed'({1'b0, atan_turn32(c - 1)});
            if (!r_cz[c-1][ZW-1]) begin
                n_cx[c] = r_cx[c-1] - (r_cy[c-1] >>> (c - 1));
                n_cy[c] = r_cy[c-1] + (r_cx[c-1] >>> (c - 1));
                n_cz[c] = r_cz[c-1] - a;
            end else begin
                n_cx[c] = r_cx[c-1] + (r_cy[c-1] >>> (c - 1));
                n_cy[c] = r_cy[c-1] - (r_cx[c-1] >>> (c - 1));
                n_cz[c] = r_cz[c-1] + a;
            end
            n_cq[c] = r_cq[c-1];
        end
    end

    // quadrant swap
    logic signed [XW-1:0] r_cos;
    logic signed [XW-1:0] r_sin;
    logic signed [XW-1:0] n_cos;
    logic signed [XW-1:0] n_sin;

    always_comb begin
        case (r_cq[CS])
            2'd0: begin
                n_cos = r_cx[CS];
                n_sin = r_cy[CS];
            end
            2'd1: begin
                n_cos = -r_cy[CS];
                n_sin = r_cx[CS];
            end
            2'd2: begin
                n_cos = -r_cx[CS];
                n_sin = -r_cy[CS];
            end
            default: begin
                n_cos = r_cy[CS];
                n_sin = -r_cx[CS];
            end
        endcase
    end

    // output rounding and saturation
    logic signed [35:0]         w_rs;
    logic signed [35:0]         w_rc;
    logic signed [OUT_BITS-1:0] r_osin;
    logic signed [OUT_BITS-1:0] r_ocos;
    logic signed [OUT_BITS-1:0] n_osin;
    logic signed [OUT_BITS-1:0] n_ocos;

    generate
        if (OSH > 0) begin : g_rnd
            assign w_rs = (36'(r_sin) + (36'sd1 <<< OSH_RND)) >>> OSH;
            assign w_rc = (36'(r_cos) + (36'sd1 <<< OSH_RND)) >>> OSH;
        end else if (OSH == 0) begin : g_keep
            assign w_rs = 36'(r_sin);
            assign w_rc = 36'(r_cos);
        end else begin : g_dbl
            assign w_rs = 36'(r_sin) <<< 1;
            assign w_rc = 36'(r_cos) <<< 1;
        end
    endgenerate

    always_comb begin
        if (w_rs > OUT_HI) begin
            n_osin = OUT_HI[OUT_BITS-1:0];
        end else if (w_rs < OUT_LO) begin
            n_osin = OUT_LO[OUT_BITS-1:0];
        end else begin
            n_osin = w_rs[OUT_BITS-1:0];
        end
        if (w_rc > OUT_HI) begin
            n_ocos = OUT_HI[OUT_BITS-1:0];
        end else if (w_rc < OUT_LO) begin
            n_ocos = OUT_LO[OUT_BITS-1:0];
        end else begin
            n_ocos = w_rc[OUT_BITS-1:0];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mrem  <= n_mrem;
        r_mstep <= n_mstep;
        r_mzero <= n_mzero;
        r_prem  <= n_prem;
        r_pq    <= n_pq;
        r_pzero <= n_pzero;
        r_phase <= n_phase;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cz    <= n_cz;
        r_cq    <= n_cq;
        r_cos   <= n_cos;
        r_sin   <= n_sin;
        r_osin  <= n_osin;
        r_ocos  <= n_ocos;
    end

    assign busy       = 1'b0;
    assign o_valid    = r_vld[V_LEN-1];
    assign o_sine_x   = r_osin;
    assign o_cosine_y = r_ocos;

    // accepted item enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> r_vld[0])
        else $error("accepted item not in first stage");

    // modulo remainder stays below the turn size
    a_mrem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_PH-1] |-> (r_mrem[15] < w_n))
        else $error("modulo remainder out of range");

    // divider remainder stays below the turn size
    a_prem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_RND-1] |-> (r_prem[AB-1] < w_n))
        else $error("phase remainder out of range");

    // residue angle after quadrant pick is within an eighth of a turn
    a_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_COR] |-> (r_cz[0] >= -(33'sd1 <<< 29)) && (r_cz[0] < (33'sd1 <<< 29)))
        else $error("cordic residue angle out of range");

    // quadrant code survives the rotation stages
    a_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_SWP-1] |-> (r_cq[CS] == $past(r_cq[0], CS)))
        else $error("quadrant code lost in cordic stages");

endmodule
